// ----- hw/rtl/ypcam_pkg.sv -----
// Shared constants, types and CORDIC helpers for the yaw/pitch camera pose unit.
package ypcam_pkg;

  localparam int CORDIC_STEPS   = 16;
  localparam int POSITION_WIDTH = 32;
  localparam int TABLE_LEN      = 24;
  localparam int STEP_W         = $clog2(TABLE_LEN);
  localparam int CW             = 34;                  // CORDIC datapath, Q2.30 plus headroom
  localparam int ACC_W          = POSITION_WIDTH + 15; // Q16.16 x Q1.15 sums, wrap-relevant bits

  typedef logic signed [CW-1:0]             cord_t;
  typedef logic signed [15:0]               q15_t;
  typedef logic signed [14:0]               tlim_t;
  typedef logic signed [ACC_W-1:0]          acc_t;
  typedef logic signed [POSITION_WIDTH-1:0] pos_t;
  typedef logic [STEP_W-1:0]                step_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    cord_t z;
    logic  flip;
  } lane_t;

  localparam cord_t GAIN_Q30 = 34'sd652032874;

  // Arctangent of 2^-i, 2^32 units per turn.
  function automatic cord_t atan_step(step_t i);
    cord_t v;
    unique case (i)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Fold the angle into the right half plane, then scale to the residual units.
  function automatic lane_t lane_init(logic [15:0] a);
    lane_t l;
    logic [15:0] red;
    l.flip = a[15] ^ a[14];
    red    = a ^ {l.flip, 15'd0};
    l.x    = GAIN_Q30;
    l.y    = '0;
    l.z    = {{2{red[15]}}, red, 16'd0};
    return l;
  endfunction

  function automatic lane_t cordic_step(lane_t l, step_t i);
    lane_t n;
    cord_t xs;
    cord_t ys;
    xs = l.x >>> i;
    ys = l.y >>> i;
    n.flip = l.flip;
    if (!l.z[CW-1]) begin
      n.x = l.x - ys;
      n.y = l.y + xs;
      n.z = l.z - atan_step(i);
    end else begin
      n.x = l.x + ys;
      n.y = l.y - xs;
      n.z = l.z + atan_step(i);
    end
    return n;
  endfunction

  // Round Q2.30 to Q1.15 and saturate.
  function automatic q15_t to_q15(cord_t v);
    cord_t r;
    q15_t  q;
    r = (v + CW'(16384)) >>> 15;
    if (r > CW'(32767))
      q = 16'sh7FFF;
    else if (r < -CW'(32768))
      q = 16'sh8000;
    else
      q = r[15:0];
    return q;
  endfunction

endpackage

// ----- hw/rtl/yaw_pitch_camera_pose_update_top.sv -----
// Yaw/pitch fly camera pose unit: heading, clamped tilt, position and forward vector.
//
//   channel   | dir | beat contents (lowest bits first)
//   ----------+-----+-----------------------------------------------------------
//   s_*       | in  | tuser: kind; tdata: delta_heading, delta_tilt, forward_delta,
//             |     |        right_delta, up_delta
//   m_*       | out | tdata: pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z, heading, tilt
//   APB       | cfg | 0x0 min_tilt, 0x4 max_tilt (15-bit signed, read sign-extended)
//
// An accepted beat passes through S_INIT, S_CORDIC, S_ROUND, S_MUL and S_DONE,
// then returns to idle, where s_tready is high again; no new beat is taken
// until the last one has left S_DONE.
// The CORDIC iterations dominate: both angle lanes advance together, one
// micro-rotation a cycle; a single 32x16 multiplier then takes seven products.
// The result sits in an output register, so a new beat is taken while it waits;
// a second result waits in the final state until m_tready frees that register.
// rst is synchronous and restores the pose to zero and the tilt limits to +-15474.
module yaw_pitch_camera_pose_update_top import ypcam_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // slave stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // delta_heading, delta_tilt, forward_delta, right_delta, up_delta
  input  logic         s_tuser,  // kind: 0 rotate, 1 move
  // master stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,  // pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z, heading, tilt, pad
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_CORDIC = 3'd2;
  localparam logic [2:0] S_ROUND  = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic KIND_MOVE = 1'b1;

  // multiplier schedule, one product issued per cycle
  localparam logic [2:0] OP_FX  = 3'd0;  // sin h * cos t
  localparam logic [2:0] OP_FZ  = 3'd1;  // cos h * cos t
  localparam logic [2:0] OP_XF  = 3'd2;  // f * fwd_x
  localparam logic [2:0] OP_XR  = 3'd3;  // r * cos h
  localparam logic [2:0] OP_YF  = 3'd4;  // f * fwd_y
  localparam logic [2:0] OP_ZF  = 3'd5;  // f * fwd_z
  localparam logic [2:0] OP_ZR  = 3'd6;  // r * sin h (subtracted)
  localparam logic [2:0] OP_END = 3'd7;

  localparam logic REG_MIN = 1'b0;

  logic [2:0]  state;
  step_t       step;
  logic [2:0]  mcnt;
  logic [2:0]  aop;

  tlim_t       min_tilt;
  tlim_t       max_tilt;
  logic [15:0] heading;
  logic signed [15:0] tilt;
  pos_t        pos_x;
  pos_t        pos_y;
  pos_t        pos_z;
  pos_t        pos_x_next;
  pos_t        pos_y_next;
  pos_t        pos_z_next;

  logic        kind;
  logic signed [31:0] fdel;
  logic signed [31:0] rdel;

  lane_t       lane_h;
  lane_t       lane_t_;
  q15_t        sh;
  q15_t        ch;
  q15_t        st;
  q15_t        ct;
  q15_t        fx;
  q15_t        fz;

  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [47:0] prod;
  logic signed [47:0] prod_rnd;
  acc_t        acc_x;
  acc_t        acc_y;
  acc_t        acc_z;

  logic signed [16:0] tilt_sum;
  logic signed [16:0] tilt_hi;
  logic signed [16:0] tilt_new;

  logic        in_beat;
  logic        cfg_wr;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_MIN) ? 32'(min_tilt) : 32'(max_tilt);

  // Tilt update: limit to max first, then raise to min, so min wins when crossed.
  always_comb begin
    tilt_sum = 17'(tilt) + 17'($signed(s_tdata[31:16]));
    tilt_hi  = (tilt_sum > 17'(max_tilt)) ? 17'(max_tilt) : tilt_sum;
    tilt_new = (tilt_hi < 17'(min_tilt)) ? 17'(min_tilt) : tilt_hi;
  end

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (mcnt)
      OP_FX:   begin mul_a = 32'(sh); mul_b = ct; end
      OP_FZ:   begin mul_a = 32'(ch); mul_b = ct; end
      OP_XF:   begin mul_a = fdel;    mul_b = fx; end
      OP_XR:   begin mul_a = rdel;    mul_b = ch; end
      OP_YF:   begin mul_a = fdel;    mul_b = st; end
      OP_ZF:   begin mul_a = fdel;    mul_b = fz; end
      OP_ZR:   begin mul_a = rdel;    mul_b = sh; end
      default: begin mul_a = '0;      mul_b = '0; end
    endcase
  end

  assign aop      = mcnt - 3'd1;
  assign prod_rnd = prod + 48'sd16384;

  // Accumulators already carry the rounding half; keep the wrapped bits only.
  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    pos_z_next = pos_z;
    if (kind == KIND_MOVE) begin
      pos_x_next = pos_x + pos_t'(acc_x[ACC_W-1:15]);
      pos_y_next = pos_y + pos_t'(acc_y[ACC_W-1:15]);
      pos_z_next = pos_z + pos_t'(acc_z[ACC_W-1:15]);
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      mcnt     <= '0;
      m_tvalid <= 1'b0;
      min_tilt <= -15'sd15474;
      max_tilt <= 15'sd15474;
      heading  <= '0;
      tilt     <= '0;
      pos_x    <= '0;
      pos_y    <= '0;
      pos_z    <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_MIN)
          min_tilt <= tlim_t'(pwdata[14:0]);
        else
          max_tilt <= tlim_t'(pwdata[14:0]);
      end

      // raise valid as the final state loads the output register, drop it once taken
      if (state == S_DONE && (!m_tvalid || m_tready))
        m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)
        m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            if (s_tuser != KIND_MOVE) begin
              heading <= heading + s_tdata[15:0];
              tilt    <= 16'(tilt_new);
            end
            state <= S_INIT;
          end
        end
        S_INIT: begin
          step  <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          step <= step + step_t'(1);
          if (step == step_t'(CORDIC_STEPS - 1))
            state <= S_ROUND;
        end
        S_ROUND: begin
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          mcnt <= mcnt + 3'd1;
          if (mcnt == OP_END)
            state <= S_DONE;
        end
        S_DONE: begin
          // hold here while the previous result still waits downstream
          if (!m_tvalid || m_tready) begin
            pos_x    <= pos_x_next;
            pos_y    <= pos_y_next;
            pos_z    <= pos_z_next;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          kind  <= s_tuser;
          fdel  <= $signed(s_tdata[63:32]);
          rdel  <= $signed(s_tdata[95:64]);
          // up term enters as u * 2^15 plus the rounding half
          acc_y <= acc_t'($signed({s_tdata[127:96], 15'h4000}));
        end
      end
      S_INIT: begin
        lane_h  <= lane_init(heading);
        lane_t_ <= lane_init(tilt);
      end
      S_CORDIC: begin
        lane_h  <= cordic_step(lane_h, step);
        lane_t_ <= cordic_step(lane_t_, step);
      end
      S_ROUND: begin
        sh <= to_q15(lane_h.flip  ? -lane_h.y  : lane_h.y);
        ch <= to_q15(lane_h.flip  ? -lane_h.x  : lane_h.x);
        st <= to_q15(lane_t_.flip ? -lane_t_.y : lane_t_.y);
        ct <= to_q15(lane_t_.flip ? -lane_t_.x : lane_t_.x);
      end
      S_MUL: begin
        prod <= 48'(mul_a) * 48'(mul_b);
        if (mcnt != OP_FX) begin
          unique case (aop)
            OP_FX:   fx    <= prod_rnd[30:15];
            OP_FZ:   fz    <= prod_rnd[30:15];
            OP_XF:   acc_x <= acc_t'(prod) + acc_t'(16384);
            OP_XR:   acc_x <= acc_x + acc_t'(prod);
            OP_YF:   acc_y <= acc_y + acc_t'(prod);
            OP_ZF:   acc_z <= acc_t'(prod) + acc_t'(16384);
            OP_ZR:   acc_z <= acc_z - acc_t'(prod);
            default: acc_x <= acc_x;
          endcase
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready)
          m_tdata <= {1'b0, tilt[14:0], heading, fz, st, fx,
                      32'(pos_z_next), 32'(pos_y_next), 32'(pos_x_next)};
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sim/camera_pose_checker.sv -----
// Pose checker for the yaw/pitch camera unit: stream monitor, pose predictor, compare.
`timescale 1ns / 1ps

package ypcam_tb_pkg;

  typedef enum logic {
    KIND_ROTATE = 1'b0,
    KIND_MOVE   = 1'b1
  } step_kind_e;

  localparam logic [2:0] ADDR_MIN_TILT = 3'h0;
  localparam logic [2:0] ADDR_MAX_TILT = 3'h4;

endpackage

module camera_pose_checker
  import ypcam_pkg::*;
  import ypcam_tb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [175:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic [31:0]  prdata,
  input  logic         pready,
  output int           pending,
  output int           mismatch_count
);

  localparam longint CORDIC_GAIN = 652032874;
  localparam int     ATAN_LEN    = 24;
  localparam int     SHOW_LIMIT  = 40;
  localparam longint ATAN_UNITS [ATAN_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    q15_t               fwd_x;
    q15_t               fwd_y;
    q15_t               fwd_z;
    logic [15:0]        heading;
    tlim_t              tilt;
  } pose_t;

  pose_t pose_q[$];

  int                        min_tilt_q;
  int                        max_tilt_q;
  logic [15:0]               heading_q;
  int                        tilt_q;
  logic [POSITION_WIDTH-1:0] cam_x;
  logic [POSITION_WIDTH-1:0] cam_y;
  logic [POSITION_WIDTH-1:0] cam_z;
  int                        shown;

  function automatic q15_t round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return q15_t'(r);
  endfunction

  // Rotation-mode CORDIC; angles outside the right half plane are folded by half a turn.
  function automatic void sine_cosine(input logic [15:0] ang, output q15_t s, output q15_t c);
    int     sa;
    bit     flip;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    sa   = $signed(ang);
    flip = 1'b0;
    if (sa < -16384 || sa > 16383) begin
      sa   = (sa >= 0) ? sa - 32768 : sa + 32768;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = longint'(sa) * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_UNITS[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_UNITS[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = round_q15(y);
    c = round_q15(x);
  endfunction

  // Apply one beat to the tracked pose and return the result it should produce.
  function automatic pose_t advance_pose(step_kind_e kind, logic [127:0] d);
    pose_t  p;
    int     t;
    q15_t   sh;
    q15_t   ch;
    q15_t   st;
    q15_t   ct;
    longint fx;
    longint fy;
    longint fz;
    longint f;
    longint r;
    longint u;
    longint dx;
    longint dy;
    longint dz;
    if (kind == KIND_ROTATE) begin
      heading_q = heading_q + d[15:0];
      t = tilt_q + int'($signed(d[31:16]));
      // max first, then min: crossed limits leave min_tilt in charge
      if (t > max_tilt_q) t = max_tilt_q;
      if (t < min_tilt_q) t = min_tilt_q;
      tilt_q = t;
    end
    sine_cosine(heading_q, sh, ch);
    sine_cosine(16'(tilt_q), st, ct);
    fx = (longint'(sh) * longint'(ct) + 16384) >>> 15;
    fy = longint'(st);
    fz = (longint'(ch) * longint'(ct) + 16384) >>> 15;
    if (kind == KIND_MOVE) begin
      f  = longint'($signed(d[63:32]));
      r  = longint'($signed(d[95:64]));
      u  = longint'($signed(d[127:96]));
      dx = f * fx + r * longint'(ch);
      dy = f * fy + u * 32768;
      dz = f * fz - r * longint'(sh);
      cam_x = cam_x + POSITION_WIDTH'((dx + 16384) >>> 15);
      cam_y = cam_y + POSITION_WIDTH'((dy + 16384) >>> 15);
      cam_z = cam_z + POSITION_WIDTH'((dz + 16384) >>> 15);
    end
    p.pos_x   = 32'($signed(cam_x));
    p.pos_y   = 32'($signed(cam_y));
    p.pos_z   = 32'($signed(cam_z));
    p.fwd_x   = q15_t'(fx);
    p.fwd_y   = q15_t'(fy);
    p.fwd_z   = q15_t'(fz);
    p.heading = heading_q;
    p.tilt    = tlim_t'(tilt_q);
    return p;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      if (shown < SHOW_LIMIT)
        $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      shown++;
    end
  endfunction

  always @(posedge clk) begin
    pose_t want;
    pose_t got;
    if (rst) begin
      pose_q.delete();
      min_tilt_q     = -15474;
      max_tilt_q     = 15474;
      heading_q      = '0;
      tilt_q         = 0;
      cam_x          = '0;
      cam_y          = '0;
      cam_z          = '0;
      shown          = 0;
      mismatch_count = 0;
    end else begin
      // check the outgoing beat first so a stray result never meets a fresh entry
      if (m_tvalid && m_tready) begin
        got.pos_x   = m_tdata[31:0];
        got.pos_y   = m_tdata[63:32];
        got.pos_z   = m_tdata[95:64];
        got.fwd_x   = m_tdata[111:96];
        got.fwd_y   = m_tdata[127:112];
        got.fwd_z   = m_tdata[143:128];
        got.heading = m_tdata[159:144];
        got.tilt    = m_tdata[174:160];
        if (pose_q.size() == 0) begin
          mismatch_count++;
          if (shown < SHOW_LIMIT)
            $display("%0t result beat: expected none, actual %h", $time, m_tdata);
          shown++;
        end else begin
          want = pose_q.pop_front();
          check_field("pos_x", want.pos_x, got.pos_x);
          check_field("pos_y", want.pos_y, got.pos_y);
          check_field("pos_z", want.pos_z, got.pos_z);
          check_field("fwd_x", want.fwd_x, got.fwd_x);
          check_field("fwd_y", want.fwd_y, got.fwd_y);
          check_field("fwd_z", want.fwd_z, got.fwd_z);
          check_field("heading", want.heading, got.heading);
          check_field("tilt", want.tilt, got.tilt);
        end
      end
      if (s_tvalid && s_tready)
        pose_q.push_back(advance_pose(step_kind_e'(s_tuser), s_tdata));
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            ADDR_MIN_TILT: min_tilt_q = int'($signed(pwdata[14:0]));
            ADDR_MAX_TILT: max_tilt_q = int'($signed(pwdata[14:0]));
            default: ;
          endcase
        end else begin
          case (paddr)
            ADDR_MIN_TILT: check_field("min_tilt", tlim_t'(min_tilt_q), $signed(prdata[14:0]));
            ADDR_MAX_TILT: check_field("max_tilt", tlim_t'(max_tilt_q), $signed(prdata[14:0]));
            default: ;
          endcase
        end
      end
    end
    pending = pose_q.size();
  end

endmodule

// ----- sim/tb_yaw_pitch_camera_pose_update_top.sv -----
// Testbench top for the yaw/pitch camera pose unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_yaw_pitch_camera_pose_update_top;
  import ypcam_pkg::*;
  import ypcam_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000; // quiet cycles; longest legal gap is the long hold
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 2 * (CORDIC_STEPS + 12);
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 213;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;  // delta_heading, delta_tilt, forward_delta, right_delta, up_delta
  logic         s_tuser;  // kind
  logic         m_tvalid;
  logic         m_tready;
  logic [175:0] m_tdata;  // pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z, heading, tilt, pad
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int pending;
  int mismatch_count;
  int quiet;
  int gap_pct;    // chance of a sender gap before a beat, in percent
  bit calm;       // no idling on either side once set
  bit long_hold;  // ask the sink for one long stall

  yaw_pitch_camera_pose_update_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  camera_pose_checker pose_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pending        (pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if no beat moves on either stream for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result sink: random stall bursts, a varying stall rate, one long hold on request.
  initial begin : sink
    int stall_pct;
    int cyc;
    bit held;
    m_tready  = 1'b0;
    stall_pct = 0;
    cyc       = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 5;
          2: stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      cyc++;
      if (long_hold && !held) begin
        // hold off long enough for the block to fill and drop s_tready
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [127:0] pack_step(logic [15:0] dh, logic [15:0] dt,
                                             logic [31:0] f, logic [31:0] r, logic [31:0] u);
    return {u, r, f, dt, dh};
  endfunction

  function automatic logic [31:0] random_distance();
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  // Mix of full-range angles, small and medium nudges and exact quarter turns.
  function automatic logic [127:0] random_payload();
    logic [15:0] dh;
    logic [15:0] dt;
    case ($urandom_range(0, 3))
      0: dh = 16'($urandom);
      1: dh = 16'($urandom_range(0, 512)) - 16'd256;
      2: dh = 16'($urandom_range(0, 3)) << 14;
      default: dh = 16'($urandom_range(0, 8191)) - 16'd4096;
    endcase
    if ($urandom_range(0, 2) == 0)
      dt = 16'($urandom);
    else
      dt = 16'($urandom_range(0, 4095)) - 16'd2048;
    return pack_step(dh, dt, random_distance(), random_distance(), random_distance());
  endfunction

  // Offer one beat, with an optional sender gap first; return at the accepting edge.
  task automatic send_beat(input step_kind_e kind, input logic [127:0] payload);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= payload;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every predicted pose has come back.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reprogram both tilt limits while idle, then read them back.
  task automatic set_tilt_limits(input int lo, input int hi);
    drain_results();
    apb_access(1'b1, ADDR_MIN_TILT, 32'(lo));
    apb_access(1'b1, ADDR_MAX_TILT, 32'(hi));
    apb_access(1'b0, ADDR_MIN_TILT, '0);
    apb_access(1'b0, ADDR_MAX_TILT, '0);
  endtask

  initial begin : stimulus
    int lo;
    int hi;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = KIND_ROTATE;
    s_tdata   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = ADDR_MIN_TILT;
    pwdata    = '0;
    calm      = 1'b0;
    long_hold = 1'b0;
    gap_pct   = 20;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: pose straight out of reset, quarter and half turns, unit sine,
    // tilt clamped at both reset limits, extreme distances, ignored fields.
    send_beat(KIND_MOVE,   pack_step(16'h1234, 16'h7FFF, 32'h0001_0000, '0, '0));
    send_beat(KIND_ROTATE, pack_step(16'h4000, 16'h0000, '1, '1, '1));
    send_beat(KIND_MOVE,   pack_step(16'hFFFF, 16'h8000, 32'h0001_0000, 32'h0001_0000,
                                     32'h0001_0000));
    send_beat(KIND_ROTATE, pack_step(16'h4000, 16'h7FFF, '0, '0, '0));
    send_beat(KIND_MOVE,   pack_step('0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(KIND_ROTATE, pack_step(16'h8000, 16'h8000, '0, '0, '0));
    send_beat(KIND_MOVE,   pack_step('0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_beat(KIND_ROTATE, pack_step(16'h3FFF, 16'h4000, 32'hDEAD_BEEF, '0, '0));
    send_beat(KIND_ROTATE, pack_step(16'h0001, 16'hFFFF, '0, '0, '0));
    send_beat(KIND_ROTATE, pack_step(16'hFFFF, 16'h0000, '0, '0, '0));
    send_beat(KIND_MOVE,   pack_step('0, '0, '1, '1, '1));
    send_beat(KIND_ROTATE, pack_step(16'hC000, 16'h0000, '0, '0, '0));
    send_beat(KIND_MOVE,   pack_step('0, '0, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000));

    // Widest limits the field allows: tilt reaches +-90 degrees.
    set_tilt_limits(-16384, 16383);
    send_beat(KIND_ROTATE, pack_step('0, 16'h7FFF, '0, '0, '0));
    send_beat(KIND_MOVE,   pack_step('0, '0, 32'h0001_0000, 32'h0001_0000, '0));
    send_beat(KIND_ROTATE, pack_step('0, 16'h8000, '0, '0, '0));
    send_beat(KIND_ROTATE, pack_step('0, 16'h8000, '0, '0, '0));
    send_beat(KIND_MOVE,   pack_step('0, '0, 32'h0001_0000, 32'hFFFF_0000, '0));

    // Crossed limits: min wins whichever way tilt is pushed.
    set_tilt_limits(1000, -1000);
    send_beat(KIND_ROTATE, pack_step('0, 16'h0000, '0, '0, '0));
    send_beat(KIND_ROTATE, pack_step('0, 16'hB1E0, '0, '0, '0));
    send_beat(KIND_MOVE,   pack_step('0, '0, 32'h0002_0000, '0, 32'h0001_0000));
    send_beat(KIND_ROTATE, pack_step('0, 16'h4E20, '0, '0, '0));

    // Random phases, each under its own limits and idle rates; the last runs flat out.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          lo = -16384;
          hi = 16383;
        end
        1: begin
          lo = -int'($urandom_range(0, 16384));
          hi = int'($urandom_range(0, 16383));
        end
        2: begin
          lo = int'($urandom_range(0, 8000));
          hi = lo - int'($urandom_range(1, 8000));
        end
        default: begin
          lo = int'($urandom_range(0, 32767)) - 16384;
          hi = lo;
        end
      endcase
      set_tilt_limits(lo, hi);
      calm = (p == PHASES - 1);
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 30;
        default: gap_pct = 60;
      endcase
      if (p == 1)
        long_hold = 1'b1;
      repeat (PHASE_ITEMS)
        send_beat(step_kind_e'($urandom_range(0, 1)), random_payload());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
